// ===== src/daisy_chain_display_packet_relay_defines.svh =====
// assertion macros shared by the packet relay modules
`ifndef DAISY_CHAIN_DISPLAY_PACKET_RELAY_DEFINES_SVH
`define DAISY_CHAIN_DISPLAY_PACKET_RELAY_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define DCDR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dcdr assertion failed");
// condition that must never be true outside reset
`define DCDR_ASSERT_NEVER(label, cond) \
  `DCDR_ASSERT(label, !(cond))
`else
`define DCDR_ASSERT(label, prop)
`define DCDR_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== src/dcdr_pkg.sv =====
// shared types, constants and helpers of the packet relay
`timescale 1ns / 1ps

package dcdr_pkg;

  // header codes
  localparam logic [7:0] HDR_SEG = 8'h11;
  localparam logic [7:0] HDR_LED = 8'h12;
  localparam logic [7:0] HDR_BRT = 8'h13;
  localparam logic [7:0] HDR_RESET = 8'h20;

  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd125;
  localparam logic [4:0] STORE_TOP = 5'd16;
  localparam logic [4:0] LED_LAST = 5'd15;

  // result kinds
  localparam logic [2:0] KIND_FWD = 3'd0;
  localparam logic [2:0] KIND_CHAR = 3'd1;
  localparam logic [2:0] KIND_SEG = 3'd2;
  localparam logic [2:0] KIND_LED = 3'd3;
  localparam logic [2:0] KIND_BRT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_SHOW
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start_fwd;
    logic start_show;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic rem_busy;
    logic refresh_due;
    logic out_free;
    logic step_last;
  } status_t;

  // payload length that follows a header
  function automatic logic [4:0] payload_len(input logic [7:0] hdr);
    logic [4:0] len;
    case (hdr)
      HDR_SEG: len = 5'd3;
      HDR_LED: len = 5'd16;
      HDR_BRT: len = 5'd1;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== src/daisy_chain_display_packet_relay.sv =====
// top level of the daisy chain display packet relay
// start: an accepted item that starts a run enters the forward or show state; each emit
//   loads the output register, one result per cycle from the packet store while the output
//   is not stalled, input stalled until the run ends (forward run at most 17 words)
// reset: store holds a space header with zero payload, refresh armed, idle limit 125
`timescale 1ns / 1ps

module daisy_chain_display_packet_relay (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [3:0]  out_index_o,
  output logic [17:0] seg_word_o,
  output logic        last_o
);

  dcdr_pkg::cmd_t    cmd;
  dcdr_pkg::status_t st;

  // sequencing
  dcdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // store and results
  dcdr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_index_o (out_index_o),
    .seg_word_o  (seg_word_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

// ===== src/dcdr_ctrl.sv =====
// controller state machine of the packet relay
`timescale 1ns / 1ps
`include "daisy_chain_display_packet_relay_defines.svh"

module dcdr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dcdr_pkg::status_t st_i,
  output dcdr_pkg::cmd_t    cmd_o
);

  dcdr_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcdr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dcdr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!st_i.is_tick && !st_i.rem_busy) begin
            state_d = dcdr_pkg::ST_FWD;
          end else if (st_i.is_tick && st_i.refresh_due) begin
            state_d = dcdr_pkg::ST_SHOW;
          end
        end
      end
      dcdr_pkg::ST_FWD, dcdr_pkg::ST_SHOW: begin
        if (st_i.out_free && st_i.step_last) begin
          state_d = dcdr_pkg::ST_IDLE;
        end
      end
      default: state_d = dcdr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dcdr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.accept = in_valid_i;
        cmd_o.start_fwd = in_valid_i && !st_i.is_tick && !st_i.rem_busy;
        cmd_o.start_show = in_valid_i && st_i.is_tick && st_i.refresh_due;
      end
      dcdr_pkg::ST_FWD, dcdr_pkg::ST_SHOW: begin
        cmd_o.emit = st_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  `DCDR_ASSERT(a_emit_needs_room, cmd_o.emit |-> st_i.out_free)
  `DCDR_ASSERT(a_last_emit_ends_run, (cmd_o.emit && st_i.step_last) |=> (state_q == dcdr_pkg::ST_IDLE))
  `DCDR_ASSERT_NEVER(a_no_accept_in_run, cmd_o.accept && (state_q != dcdr_pkg::ST_IDLE))

endmodule

// ===== src/dcdr_datapath.sv =====
// packet store, idle timer, run sequencing and output register
`timescale 1ns / 1ps
`include "daisy_chain_display_packet_relay_defines.svh"

module dcdr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              req_type_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [2:0]        out_kind_o,
  output logic [7:0]        out_byte_o,
  output logic [3:0]        out_index_o,
  output logic [17:0]       seg_word_o,
  output logic              last_o,
  input  dcdr_pkg::cmd_t    cmd_i,
  output dcdr_pkg::status_t st_o
);

  logic [7:0]  idle_limit_q;
  logic [7:0]  hdr_q;
  logic [7:0]  payload_q [16];
  logic [4:0]  rem_q;
  logic [4:0]  wp_q;
  logic [7:0]  idle_cnt_q;
  logic        armed_q;
  logic [7:0]  run_hdr_q;
  logic        run_show_q;
  logic [4:0]  step_q;
  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [7:0]  out_byte_q;
  logic [3:0]  out_index_q;
  logic [17:0] seg_word_q;
  logic        last_q;

  logic [7:0]  idle_next;
  logic [4:0]  wp_dec;
  logic [4:0]  fwd_pos;
  logic [2:0]  res_kind;
  logic [7:0]  res_byte;
  logic [3:0]  res_index;
  logic [17:0] res_seg;
  logic        res_last;

  // saturating idle count after this tick
  assign idle_next = (idle_cnt_q == 8'hFF) ? idle_cnt_q : idle_cnt_q + 8'd1;
  assign wp_dec = wp_q - 5'd1;

  // status toward the controller
  assign st_o.is_tick = req_type_i;
  assign st_o.rem_busy = (rem_q != 5'd0);
  assign st_o.refresh_due = armed_q && (idle_next >= idle_limit_q);
  assign st_o.out_free = !out_valid_q || !out_stall_i;
  assign st_o.step_last = res_last;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= dcdr_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      idle_limit_q <= cfg_wdata_i;
    end
  end

  // packet store, payload counters and idle timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= dcdr_pkg::HDR_RESET;
      for (int i = 0; i < 16; i++) begin
        payload_q[i] <= 8'd0;
      end
      rem_q <= 5'd0;
      wp_q <= dcdr_pkg::STORE_TOP;
      idle_cnt_q <= 8'd0;
      armed_q <= 1'b1;
      run_hdr_q <= dcdr_pkg::HDR_RESET;
      run_show_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (!req_type_i) begin
        idle_cnt_q <= 8'd0;
        armed_q <= 1'b1;
        if (rem_q != 5'd0) begin
          // payload word goes below the previous one
          if (wp_q != 5'd0) begin
            wp_q <= wp_dec;
            payload_q[wp_dec[3:0]] <= rx_byte_i;
          end
          rem_q <= rem_q - 5'd1;
        end else begin
          // new header: remember the old one for the forward run
          run_hdr_q <= hdr_q;
          run_show_q <= 1'b0;
          hdr_q <= rx_byte_i;
          wp_q <= dcdr_pkg::STORE_TOP;
          rem_q <= dcdr_pkg::payload_len(rx_byte_i);
        end
      end else if (armed_q) begin
        if (idle_next >= idle_limit_q) begin
          armed_q <= 1'b0;
          idle_cnt_q <= 8'd0;
          run_hdr_q <= hdr_q;
          run_show_q <= 1'b1;
        end else begin
          idle_cnt_q <= idle_next;
        end
      end
    end
  end

  // run step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 5'd0;
    end else if (cmd_i.start_fwd || cmd_i.start_show) begin
      step_q <= 5'd0;
    end else if (cmd_i.emit && !res_last) begin
      step_q <= step_q + 5'd1;
    end
  end

  // result word for the current step
  assign fwd_pos = dcdr_pkg::STORE_TOP - step_q;
  always_comb begin
    res_kind = dcdr_pkg::KIND_FWD;
    res_byte = 8'd0;
    res_index = 4'd0;
    res_seg = 18'd0;
    res_last = 1'b1;
    if (!run_show_q) begin
      res_byte = (step_q == 5'd0) ? run_hdr_q : payload_q[fwd_pos[3:0]];
      res_last = (step_q == dcdr_pkg::payload_len(run_hdr_q));
    end else begin
      case (run_hdr_q)
        dcdr_pkg::HDR_LED: begin
          res_kind = dcdr_pkg::KIND_LED;
          res_byte = payload_q[step_q[3:0]];
          res_index = step_q[3:0];
          res_last = (step_q == dcdr_pkg::LED_LAST);
        end
        dcdr_pkg::HDR_SEG: begin
          res_kind = dcdr_pkg::KIND_SEG;
          res_seg = {payload_q[13][1:0], payload_q[14], payload_q[15]};
        end
        dcdr_pkg::HDR_BRT: begin
          res_kind = dcdr_pkg::KIND_BRT;
          res_byte = payload_q[15];
        end
        default: begin
          res_kind = dcdr_pkg::KIND_CHAR;
          res_byte = run_hdr_q;
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_index_q <= res_index;
      seg_word_q <= res_seg;
      last_q <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o = out_kind_q;
  assign out_byte_o = out_byte_q;
  assign out_index_o = out_index_q;
  assign seg_word_o = seg_word_q;
  assign last_o = last_q;

  `DCDR_ASSERT(a_wp_in_range, wp_q <= dcdr_pkg::STORE_TOP)
  `DCDR_ASSERT(a_rem_in_range, rem_q <= dcdr_pkg::STORE_TOP)
  `DCDR_ASSERT(a_disarmed_count_clear, !armed_q |-> (idle_cnt_q == 8'd0))

endmodule
